### rtl/bppd_pkg.sv
// Shared types, constants and palette functions of the bit-plane pixel decoder.
// No dependencies; used by every module under rtl/.
package bppd_pkg;

    // Bytes in one shown page; offsets at or above this are dropped.
    localparam int PAGE_BYTES = 12288;

    // Depth of the item queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes (register i sits at byte address 4*i).
    localparam logic REG_DISPLAY_MODE = 1'b0;
    localparam logic REG_FRAME_SELECT = 1'b1;

    // Display modes, coded by display_mode[2:1].
    localparam logic [1:0] MODE_MONO    = 2'b00;
    localparam logic [1:0] MODE_BLANK   = 2'b01;
    localparam logic [1:0] MODE_FOUR    = 2'b10;
    localparam logic [1:0] MODE_SIXTEEN = 2'b11;

    // One classified video byte, as queued between front and back.
    typedef struct packed {
        logic [5:0]  column;
        logic [7:0]  line;
        logic [15:0] addr;
        logic [2:0]  mode;
        logic [7:0]  main_byte;
        logic [7:0]  color_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic rgb_t mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        rgb_t c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    function automatic rgb_t pal_mono(input logic [1:0] idx);
        rgb_t c;
        unique case (idx)
            2'd0: c = mk_rgb(8'd0,   8'd0,   8'd0);
            2'd1: c = mk_rgb(8'd0,   8'd255, 8'd0);
            2'd2: c = mk_rgb(8'd40,  8'd180, 8'd200);
            2'd3: c = mk_rgb(8'd250, 8'd250, 8'd50);
            default: c = mk_rgb(8'd0, 8'd0, 8'd0);
        endcase
        return c;
    endfunction

    function automatic rgb_t pal_four(input logic [2:0] idx);
        rgb_t c;
        unique case (idx)
            3'd0: c = mk_rgb(8'd0,   8'd0,   8'd0);
            3'd1: c = mk_rgb(8'd127, 8'd0,   8'd0);
            3'd2: c = mk_rgb(8'd0,   8'd127, 8'd0);
            3'd3: c = mk_rgb(8'd0,   8'd0,   8'd127);
            3'd4: c = mk_rgb(8'd127, 8'd127, 8'd127);
            3'd5: c = mk_rgb(8'd0,   8'd127, 8'd127);
            3'd6: c = mk_rgb(8'd127, 8'd0,   8'd127);
            3'd7: c = mk_rgb(8'd127, 8'd127, 8'd0);
            default: c = mk_rgb(8'd0, 8'd0, 8'd0);
        endcase
        return c;
    endfunction

    function automatic rgb_t pal_sixteen(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:  c = mk_rgb(8'd0,   8'd0,   8'd0);
            4'd1:  c = mk_rgb(8'd0,   8'd0,   8'd127);
            4'd2:  c = mk_rgb(8'd0,   8'd127, 8'd0);
            4'd3:  c = mk_rgb(8'd0,   8'd127, 8'd127);
            4'd4:  c = mk_rgb(8'd127, 8'd0,   8'd0);
            4'd5:  c = mk_rgb(8'd127, 8'd0,   8'd127);
            4'd6:  c = mk_rgb(8'd127, 8'd127, 8'd0);
            4'd7:  c = mk_rgb(8'd127, 8'd127, 8'd127);
            4'd8:  c = mk_rgb(8'd127, 8'd127, 8'd127);
            4'd9:  c = mk_rgb(8'd0,   8'd0,   8'd255);
            4'd10: c = mk_rgb(8'd0,   8'd255, 8'd0);
            4'd11: c = mk_rgb(8'd0,   8'd255, 8'd255);
            4'd12: c = mk_rgb(8'd255, 8'd0,   8'd0);
            4'd13: c = mk_rgb(8'd255, 8'd0,   8'd255);
            4'd14: c = mk_rgb(8'd255, 8'd255, 8'd0);
            4'd15: c = mk_rgb(8'd255, 8'd255, 8'd255);
            default: c = mk_rgb(8'd0, 8'd0, 8'd0);
        endcase
        return c;
    endfunction

    // Color of one pixel: mode, main bit, color bit and the whole color byte.
    function automatic rgb_t pixel_color(input logic [2:0] mode, input logic mb,
                                         input logic cb, input logic [7:0] colb);
        rgb_t c;
        unique case (mode[2:1])
            MODE_MONO:    c = pal_mono({mode[0], mb});
            MODE_BLANK:   c = mk_rgb(8'd0, 8'd0, 8'd0);
            MODE_FOUR:    c = pal_four({mode[0], mb, cb});
            MODE_SIXTEEN: c = pal_sixteen(mb ? colb[3:0] : colb[7:4]);
            default:      c = mk_rgb(8'd0, 8'd0, 8'd0);
        endcase
        return c;
    endfunction

endpackage

### rtl/bppd_front.sv
// Front part: accepts video bytes, drops off-page offsets, splits the offset
// and forms the source address. Depends on bppd_pkg.
module bppd_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [13:0]         s_screen_offset,
    input  logic [7:0]          s_main_byte,
    input  logic [7:0]          s_color_byte,
    input  logic [2:0]          display_mode,
    input  logic [1:0]          frame_select,
    output logic                push_valid,
    input  logic                push_ready,
    output bppd_pkg::item_t     push_item
);

    logic in_page;

    // 15-bit compare so a full 16 KiB page still works
    assign in_page = {1'b0, s_screen_offset} < 15'(bppd_pkg::PAGE_BYTES);

    // Off-page items are taken and discarded without touching the queue.
    assign s_ready    = push_ready;
    assign push_valid = s_valid && in_page;

    always_comb begin
        push_item.column     = s_screen_offset[13:8];
        push_item.line       = s_screen_offset[7:0];
        // page base is 0xC000 - page*0x4000, i.e. top two bits = ~page
        push_item.addr       = {~frame_select, s_screen_offset};
        push_item.mode       = display_mode;
        push_item.main_byte  = s_main_byte;
        push_item.color_byte = s_color_byte;
    end

endmodule

### rtl/bppd_queue.sv
// Small item queue between front and back parts.
// Depends on bppd_pkg.
module bppd_queue #(
    parameter int DEPTH = bppd_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  bppd_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output bppd_pkg::item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bppd_pkg::item_t entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/bppd_back.sv
// Back part: walks one queued byte bit 7 down to bit 0 into the output register,
// one pixel per cycle unless m_ready holds it. Depends on bppd_pkg.
module bppd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  bppd_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [8:0]      m_pixel_x,
    output logic [7:0]      m_pixel_y,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue,
    output logic [15:0]     m_source_address,
    output logic            m_last_pixel
);

    bppd_pkg::item_t cur_reg;
    logic            busy_reg, busy_next;
    logic [2:0]      idx_reg;
    logic            load;
    logic            done;
    logic [2:0]      bit_sel;
    bppd_pkg::rgb_t  color;

    logic            m_valid_reg;
    logic [8:0]      pixel_x_reg;
    logic [7:0]      pixel_y_reg;
    bppd_pkg::rgb_t  color_reg;
    logic [15:0]     addr_reg;
    logic            last_reg;

    assign load    = busy_reg && (!m_valid_reg || m_ready);
    assign done    = load && (idx_reg == 3'd7);
    assign q_ready = !busy_reg || done;
    assign bit_sel = ~idx_reg;   // pixel k uses bit 7-k
    assign color   = bppd_pkg::pixel_color(cur_reg.mode, cur_reg.main_byte[bit_sel],
                                           cur_reg.color_byte[bit_sel], cur_reg.color_byte);

    always_comb begin
        busy_next = busy_reg;
        if (q_valid && q_ready) begin
            busy_next = 1'b1;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (q_valid && q_ready) begin
                idx_reg <= 3'd0;
            end else if (load) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            cur_reg <= q_item;
        end
        if (load) begin
            pixel_x_reg <= {cur_reg.column, idx_reg};
            pixel_y_reg <= cur_reg.line;
            color_reg   <= color;
            addr_reg    <= cur_reg.addr;
            last_reg    <= idx_reg == 3'd7;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pixel_x        = pixel_x_reg;
    assign m_pixel_y        = pixel_y_reg;
    assign m_red            = color_reg.red;
    assign m_green          = color_reg.green;
    assign m_blue           = color_reg.blue;
    assign m_source_address = addr_reg;
    assign m_last_pixel     = last_reg;

endmodule

### rtl/bitplane_pixel_palette_decoder.sv
// Top level of the bit-plane pixel palette decoder: APB registers, front,
// queue and back. Depends on bppd_pkg, bppd_front, bppd_queue, bppd_back.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready   | screen_offset, main_byte, color_byte
//  m_       | out       | m_valid / m_ready   | pixel_x/y, red/green/blue,
//           |           |                     | source_address, last_pixel
//  APB      | in        | psel/penable, pready| display_mode @0x0, frame_select @0x4
//
// Each in-page item yields eight pixel items, one per clock while m_ready is
// high; the back part takes the next item as it emits the last pixel of a byte.
// An accepted item goes through the queue entry and cur_reg to the output register.
// Items with an offset at or past the page size are accepted and dropped.
// Reset (aresetn low, synchronous) empties the queue and output register and
// clears both registers to zero. m_ready low holds the current pixel; the
// queue keeps taking input items until it is full.
module bitplane_pixel_palette_decoder #(
    parameter int QUEUE_DEPTH = bppd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [13:0] s_screen_offset,
    input  logic [7:0]  s_main_byte,
    input  logic [7:0]  s_color_byte,
    // pixel items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_pixel_x,
    output logic [7:0]  m_pixel_y,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [15:0] m_source_address,
    output logic        m_last_pixel
);

    logic [2:0]      display_mode_reg;
    logic [1:0]      frame_select_reg;
    logic            cfg_write;

    logic            push_valid, push_ready;
    bppd_pkg::item_t push_item;
    logic            pop_valid, pop_ready;
    bppd_pkg::item_t pop_item;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // paddr[2] picks the register; the byte lanes below it are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_mode_reg <= 3'd0;
            frame_select_reg <= 2'd0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                bppd_pkg::REG_DISPLAY_MODE: display_mode_reg <= pwdata[2:0];
                bppd_pkg::REG_FRAME_SELECT: frame_select_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bppd_pkg::REG_DISPLAY_MODE: prdata = {29'd0, display_mode_reg};
            bppd_pkg::REG_FRAME_SELECT: prdata = {30'd0, frame_select_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---- front: classify and address ----
    bppd_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_screen_offset (s_screen_offset),
        .s_main_byte     (s_main_byte),
        .s_color_byte    (s_color_byte),
        .display_mode    (display_mode_reg),
        .frame_select    (frame_select_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    // ---- queue: decouples input acceptance from pixel output ----
    bppd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // ---- back: one pixel per cycle unless m_ready holds it ----
    bppd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (pop_valid),
        .q_ready          (pop_ready),
        .q_item           (pop_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_x        (m_pixel_x),
        .m_pixel_y        (m_pixel_y),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_source_address (m_source_address),
        .m_last_pixel     (m_last_pixel)
    );

    // ---- assertions ----
    // last mark sits only on the rightmost pixel of a byte
    a_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_pixel == (m_pixel_x[2:0] == 3'd7)))
        else $error("last_pixel does not match pixel column");

    // inside a byte, the next pixel follows right after a taken one
    a_next_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_pixel) |=>
            (m_valid && m_pixel_x == 9'($past(m_pixel_x) + 9'd1)
             && m_pixel_y == $past(m_pixel_y)))
        else $error("pixel sequence within a byte broken");

    // off-page offsets never reach the output
    a_in_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_source_address[13:0]} < 15'(bppd_pkg::PAGE_BYTES)))
        else $error("pixel from an off-page offset");

    // input is never stalled while the queue is empty
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> pop_valid)
        else $error("input stalled with empty queue");

endmodule

### tb/bppd_pixel_checker.sv
// Pixel checker for the bit-plane pixel palette decoder: tracks the registers
// from the APB port, predicts the eight pixels of each video byte and compares.
// Depends on bppd_pkg.
`timescale 1ns / 100ps

module bppd_pixel_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [13:0] s_screen_offset,
    input  logic [7:0]  s_main_byte,
    input  logic [7:0]  s_color_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [8:0]  m_pixel_x,
    input  logic [7:0]  m_pixel_y,
    input  logic [7:0]  m_red,
    input  logic [7:0]  m_green,
    input  logic [7:0]  m_blue,
    input  logic [15:0] m_source_address,
    input  logic        m_last_pixel,
    output int          mismatches,
    output int          pending
);

    typedef struct {
        logic [8:0]  x;
        logic [7:0]  y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] addr;
        logic        last_mark;
    } pixel_t;

    localparam logic [23:0] MONO_RGB [4] = '{
        24'h000000, 24'h00FF00, 24'h28B4C8, 24'hFAFA32
    };
    localparam logic [23:0] FOUR_RGB [8] = '{
        24'h000000, 24'h7F0000, 24'h007F00, 24'h00007F,
        24'h7F7F7F, 24'h007F7F, 24'h7F007F, 24'h7F7F00
    };
    localparam logic [23:0] SIXTEEN_RGB [16] = '{
        24'h000000, 24'h00007F, 24'h007F00, 24'h007F7F,
        24'h7F0000, 24'h7F007F, 24'h7F7F00, 24'h7F7F7F,
        24'h7F7F7F, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
        24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
    };

    logic [2:0] mode_reg;
    logic [1:0] frame_reg;
    pixel_t     pixels_due[$];
    int         err_count;

    assign mismatches = err_count;

    // Eight pixels of one in-page video byte, leftmost (bit 7) first.
    function automatic void predict_byte(input logic [13:0] offs, input logic [7:0] mb,
                                         input logic [7:0] cb);
        pixel_t      px;
        logic [23:0] rgb;
        logic        mbit;
        logic        cbit;
        logic [15:0] base;
        if (offs >= bppd_pkg::PAGE_BYTES) return;
        base = 16'hC000 - {frame_reg, 14'd0};
        for (int k = 0; k < 8; k++) begin
            mbit = mb[7 - k];
            cbit = cb[7 - k];
            case (mode_reg[2:1])
                bppd_pkg::MODE_MONO:  rgb = MONO_RGB[{mode_reg[0], mbit}];
                bppd_pkg::MODE_BLANK: rgb = 24'h000000;
                bppd_pkg::MODE_FOUR:  rgb = FOUR_RGB[{mode_reg[0], mbit, cbit}];
                default:              rgb = SIXTEEN_RGB[mbit ? cb[3:0] : cb[7:4]];
            endcase
            px.x         = {offs[13:8], 3'(k)};
            px.y         = offs[7:0];
            px.red       = rgb[23:16];
            px.green     = rgb[15:8];
            px.blue      = rgb[7:0];
            px.addr      = base + {2'b00, offs};
            px.last_mark = (k == 7);
            pixels_due.insert(pixels_due.size(), px);
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_t px;
        if (!aresetn) begin
            pixels_due.delete();
            mode_reg  = '0;
            frame_reg = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $error("pixel item with none expected (x %0d, y %0d)",
                           m_pixel_x, m_pixel_y);
                    err_count++;
                end else begin
                    px = pixels_due.pop_front();
                    check_field("pixel_x", 16'(px.x), 16'(m_pixel_x));
                    check_field("pixel_y", 16'(px.y), 16'(m_pixel_y));
                    check_field("red", 16'(px.red), 16'(m_red));
                    check_field("green", 16'(px.green), 16'(m_green));
                    check_field("blue", 16'(px.blue), 16'(m_blue));
                    check_field("source_address", px.addr, m_source_address);
                    check_field("last_pixel", 16'(px.last_mark), 16'(m_last_pixel));
                end
            end
            if (s_valid && s_ready)
                predict_byte(s_screen_offset, s_main_byte, s_color_byte);
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                if (paddr[2] == bppd_pkg::REG_DISPLAY_MODE)
                    mode_reg = pwdata[2:0];
                else
                    frame_reg = pwdata[1:0];
            end
        end
        pending <= pixels_due.size();
    end

endmodule

### tb/testbench.sv
// Top of the bit-plane pixel palette decoder testbench: clock, reset, APB
// register writes, video byte stimulus and pixel backpressure, plus verdict.
// Depends on bppd_pkg, bitplane_pixel_palette_decoder and bppd_pixel_checker.
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] ADDR_DISPLAY_MODE = {bppd_pkg::REG_DISPLAY_MODE, 2'b00};
    localparam logic [2:0] ADDR_FRAME_SELECT = {bppd_pkg::REG_FRAME_SELECT, 2'b00};

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT     = 2000;  // watchdog: cycles without any handshake
    localparam int SETTLE_CYCLES  = 8;     // covers the path through queue and back part plus dropped items
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 45;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [13:0] s_screen_offset;
    logic [7:0]  s_main_byte;
    logic [7:0]  s_color_byte;
    logic        m_valid;
    logic        m_ready;
    logic [8:0]  m_pixel_x;
    logic [7:0]  m_pixel_y;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [15:0] m_source_address;
    logic        m_last_pixel;

    int mismatch_count;
    int pixels_pending;

    // sender burst shaping
    int burst_left;
    bit gaps_on;

    // receiver hold-off requests: the receiver runs one hold per increment
    int hold_asks;

    // Directed bytes: offset extremes (first, last, first dropped, top of the
    // field), full and empty planes, alternating bits and nibble patterns.
    // Three per mode; mode i uses entries 3i..3i+2.
    localparam logic [13:0] DIR_OFFS [DIRECTED_ITEMS] = '{
        14'd0,     14'd12287, 14'd12288,
        14'd16383, 14'd255,   14'd256,
        14'd8192,  14'd5000,  14'd12287,
        14'd0,     14'd12287, 14'd4095,
        14'd12032, 14'd100,   14'd7,
        14'd12032, 14'd1234,  14'd9999,
        14'd0,     14'd12287, 14'd3000,
        14'd8191,  14'd6000,  14'd11000
    };
    localparam logic [7:0] DIR_MAIN [DIRECTED_ITEMS] = '{
        8'h00, 8'hFF, 8'hA5,
        8'hFF, 8'h80, 8'h01,
        8'hFF, 8'h3C, 8'h00,
        8'hFF, 8'h55, 8'hAA,
        8'hF0, 8'hAA, 8'h0F,
        8'hF0, 8'hAA, 8'h0F,
        8'hF0, 8'h0F, 8'hA5,
        8'hFF, 8'h00, 8'h5A
    };
    localparam logic [7:0] DIR_COLOR [DIRECTED_ITEMS] = '{
        8'h00, 8'hFF, 8'h5A,
        8'h00, 8'h0F, 8'hF0,
        8'hFF, 8'hC3, 8'h00,
        8'hFF, 8'hAA, 8'h55,
        8'hCC, 8'h0F, 8'h33,
        8'hCC, 8'h0F, 8'h33,
        8'h1E, 8'hE1, 8'h96,
        8'h0F, 8'hF0, 8'h78
    };

    bitplane_pixel_palette_decoder i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_screen_offset  (s_screen_offset),
        .s_main_byte      (s_main_byte),
        .s_color_byte     (s_color_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_x        (m_pixel_x),
        .m_pixel_y        (m_pixel_y),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_source_address (m_source_address),
        .m_last_pixel     (m_last_pixel)
    );

    bppd_pixel_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_screen_offset  (s_screen_offset),
        .s_main_byte      (s_main_byte),
        .s_color_byte     (s_color_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_x        (m_pixel_x),
        .m_pixel_y        (m_pixel_y),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_source_address (m_source_address),
        .m_last_pixel     (m_last_pixel),
        .mismatches       (mismatch_count),
        .pending          (pixels_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: any handshake on either channel or the APB port restarts it.
    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: stretches of random length, each with its own readiness level;
    // a hold request parks m_ready low for a long stretch so the queue fills
    // up and s_ready drops.
    initial begin
        int hold_seen;
        int stretch_left;
        int duty;
        logic rdy;
        hold_seen    = 0;
        stretch_left = 0;
        duty         = 0;
        m_ready      = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(1, 40);
                    duty         = $urandom_range(0, 3);
                end
                stretch_left--;
                case (duty)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 4) == 0);
                endcase
                m_ready <= rdy;
                @(posedge aclk);
            end
        end
    end

    // One APB write: setup cycle, access cycle, then psel drops; pready is
    // always high, so the register takes the data at the end of the access cycle.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Block is idle once every predicted pixel is out; dropped bytes leave no
    // trace in the count, so wait SETTLE_CYCLES more for them to clear.
    task automatic wait_drained();
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Registers are written with junk in the unused upper bits to check masking.
    task automatic set_registers(input logic [2:0] mode, input logic [1:0] frame);
        logic [31:0] data;
        data      = $urandom;
        data[2:0] = mode;
        apb_write(ADDR_DISPLAY_MODE, data);
        data      = $urandom;
        data[1:0] = frame;
        apb_write(ADDR_FRAME_SELECT, data);
    endtask

    // Offers one video byte and waits for it to be taken; closes the current
    // burst with a gap, if gaps are on, when its length is used up.
    task automatic send_byte(input logic [13:0] offs, input logic [7:0] mb,
                             input logic [7:0] cb);
        s_valid         <= 1'b1;
        s_screen_offset <= offs;
        s_main_byte     <= mb;
        s_color_byte    <= cb;
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Mostly in-page offsets, some dropped ones and some page corners.
    function automatic logic [13:0] pick_offset();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 14'($urandom_range(bppd_pkg::PAGE_BYTES, 16383));
        if (r == 2) begin
            case ($urandom_range(0, 3))
                0:       return 14'd0;
                1:       return 14'(bppd_pkg::PAGE_BYTES - 1);
                2:       return 14'd255;
                default: return 14'(bppd_pkg::PAGE_BYTES - 256);
            endcase
        end
        return 14'($urandom_range(0, bppd_pkg::PAGE_BYTES - 1));
    endfunction

    function automatic logic [7:0] pick_plane_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Stimulus and verdict.
    initial begin
        logic [2:0] mode;
        logic [1:0] frame;
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_screen_offset = '0;
        s_main_byte     = '0;
        s_color_byte    = '0;
        hold_asks       = 0;
        burst_left      = 0;
        gaps_on         = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: every display mode, every frame, field extremes and
        // out-of-page offsets.
        for (int p = 0; p < 8; p++) begin
            set_registers(3'(p), 2'(p % 4));
            for (int i = 3 * p; i < 3 * p + 3; i++)
                send_byte(DIR_OFFS[i], DIR_MAIN[i], DIR_COLOR[i]);
            s_valid <= 1'b0;
            wait_drained();
        end

        // Random part: a fresh register setting per phase. One phase starts
        // with a long receiver hold so the block backs up into its input.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode  = 3'($urandom_range(0, 7));
            frame = 2'($urandom_range(0, 3));
            set_registers(mode, frame);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (p == 2)
                hold_asks <= hold_asks + 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_byte(pick_offset(), pick_plane_byte(), pick_plane_byte());
            s_valid <= 1'b0;
            wait_drained();
        end

        if (mismatch_count == 0 && pixels_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
